// ----- design/dct8_pkg.sv -----
package dct8_pkg;
    localparam int BLOCK_DIM_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int ROW_BITS        = 20;

    // round(4096 * cos(m*pi/16)), m = 0..8
    function automatic logic signed [13:0] cos_q12(input logic [3:0] m);
        logic signed [13:0] v;
        begin
            case (m)
                4'd0:    v = 14'sd4096;
                4'd1:    v = 14'sd4017;
                4'd2:    v = 14'sd3784;
                4'd3:    v = 14'sd3406;
                4'd4:    v = 14'sd2896;
                4'd5:    v = 14'sd2276;
                4'd6:    v = 14'sd1567;
                4'd7:    v = 14'sd799;
                default: v = 14'sd0;
            endcase
            return v;
        end
    endfunction

    // basis weight W[k][n], 13 fractional bits (same scale as cos_q12 with 0.5)
    function automatic logic signed [13:0] basis(input logic [2:0] k, input logic [2:0] n);
        logic [4:0] m;
        logic signed [13:0] r;
        begin
            m = 5'(({1'b0, n, 1'b0} + 5'd1) * {2'b0, k});
            if (k == 3'd0)
                r = cos_q12(4'd4);
            else begin
                if (m > 5'd16)
                    m = 5'd0 - m;
                if (m <= 5'd8)
                    r = cos_q12(m[3:0]);
                else
                    r = -cos_q12(4'(5'd16 - m));
            end
            return r;
        end
    endfunction

    // matrix element A[c][j]
    function automatic logic signed [13:0] amat(input logic dir, input logic [2:0] c,
                                                input logic [2:0] j);
        return dir ? basis(j, c) : basis(c, j);
    endfunction

    typedef struct packed {
        logic clear;
        logic acc;
    } dct8_mac_ctl_t;
endpackage

// ----- design/dct8_cell.sv -----
module dct8_cell
    import dct8_pkg::*;
#(
    parameter int IN_BITS = ROW_BITS
)
(
    input  logic                      clk,
    input  dct8_mac_ctl_t             ctl,
    input  logic signed [IN_BITS-1:0] din,
    input  logic signed [13:0]        weight,
    output logic signed [IN_BITS-1:0] dout,
    output logic signed [47:0]        acc
);
    logic signed [IN_BITS-1:0] data_reg;
    logic signed [IN_BITS+13:0] prod_reg;
    logic signed [47:0] acc_reg;
    logic prod_ok_reg;

    // data ripples down the chain; product registered before the accumulate
    always_ff @(posedge clk)
    begin
        data_reg    <= din;
        prod_reg    <= din * weight;
        prod_ok_reg <= ctl.acc;
        if (ctl.clear)
            acc_reg <= '0;
        else if (prod_ok_reg)
            acc_reg <= acc_reg + 48'(prod_reg);
    end

    assign dout = data_reg;
    assign acc  = acc_reg;
endmodule

// ----- design/dct8_ram.sv -----
module dct8_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/dct_8x8_forward_inverse.sv -----
// channel   | ports                        | handshake
// ----------+------------------------------+--------------------------------
// input     | sample_value                 | start high, busy low
// result    | result_value, is_last        | result_valid, one cycle each
// config    | direction_data               | direction_we, any time when idle
//
// One item is taken per cycle while filling. Busy rises once the 64th item
// is taken, and no new item is taken while it is high. The chain of eight
// MAC cells runs a row pass and then a column pass of eight lines each. Each
// line is eight store reads, then the last element walks down the chain and
// the sums settle. Column results go back into the input store in row-major
// order. After the last line drains from the shift row, 64 reads stream the
// results out, one strobe per cycle; each strobe follows its read through the
// store's read register and the rd_reg flag. Reset clears the control state
// only; the stores are always written before they are read. The receiver
// cannot stall.
module dct_8x8_forward_inverse
    import dct8_pkg::*;
#(
    parameter int BLOCK_DIM   = BLOCK_DIM_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic                          direction_we,
    input  logic                          direction_data,
    output logic                          result_valid,
    output logic signed [SAMPLE_BITS-1:0] result_value,
    output logic                          is_last
);
    localparam int N  = BLOCK_DIM;
    localparam int AW = $clog2(N * N);
    localparam int LW = $clog2(N);

    typedef enum logic [2:0] {S_FILL, S_ROW, S_COL, S_OUT} state_t;

    state_t state_reg;
    logic direction_reg, dir_reg;
    logic [AW-1:0] fill_reg;
    logic [LW-1:0] line_reg;   // row (row pass) or column (column pass)
    logic [4:0]    step_reg;   // 0..7 feed, then flush and store
    logic [AW-1:0] out_reg;    // read address while streaming results out
    logic          rd_reg;     // store data for the result port lands now
    logic          rd_last_reg;

    // input store; holds the samples, then the finished block
    logic in_we;
    logic [AW-1:0] in_waddr, in_raddr;
    logic [SAMPLE_BITS-1:0] in_wdata, in_rdata;
    dct8_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(N * N)) u_in_ram (
        .clk(clk), .we(in_we), .waddr(in_waddr),
        .wdata(in_wdata), .raddr(in_raddr), .rdata(in_rdata));

    // row pass store
    logic rp_we;
    logic [AW-1:0] rp_waddr, rp_raddr;
    logic [ROW_BITS-1:0] rp_wdata, rp_rdata;
    dct8_ram #(.WIDTH(ROW_BITS), .DEPTH(N * N)) u_rp_ram (
        .clk(clk), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
        .raddr(rp_raddr), .rdata(rp_rdata));

    // feed index j: read address issued at step j, data lands at step j+1
    // and ripples one cell per cycle; cell c weights it by A[c][j]
    logic [LW-1:0] j_idx;
    assign j_idx = step_reg[LW-1:0];
    assign in_raddr = (state_reg == S_OUT) ? out_reg : AW'({line_reg, j_idx});
    assign rp_raddr = AW'({j_idx, line_reg});

    logic [LW-1:0] jd_reg;     // index of data arriving from the store
    logic feed_reg, clr_reg;
    logic signed [ROW_BITS-1:0] feed_data;
    assign feed_data = (state_reg == S_ROW) ? ROW_BITS'(signed'(in_rdata))
                                            : signed'(rp_rdata);

    logic signed [ROW_BITS-1:0] chain [N+1];
    logic signed [47:0] acc [N];
    assign chain[0] = feed_data;

    // each cell sees the element in the cycle after its left neighbor; keep the
    // index and the strobe moving along with it
    logic [LW-1:0] jpipe_reg [N-1];
    logic          vpipe_reg [N-1];
    logic          cpipe_reg [N-1];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            dct8_mac_ctl_t ctl;
            logic [LW-1:0] jj;
            if (g == 0)
            begin : g_head
                assign jj        = jd_reg;
                assign ctl.acc   = feed_reg;
                assign ctl.clear = clr_reg;
            end
            else
            begin : g_tail
                assign jj        = jpipe_reg[g-1];
                assign ctl.acc   = vpipe_reg[g-1];
                assign ctl.clear = cpipe_reg[g-1];
            end
            dct8_cell #(.IN_BITS(ROW_BITS)) u_cell (
                .clk(clk), .ctl(ctl), .din(chain[g]),
                .weight(amat(dir_reg, LW'(g), jj)),
                .dout(chain[g+1]), .acc(acc[g]));
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                vpipe_reg[i] <= 1'b0;
                cpipe_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vpipe_reg[0] <= feed_reg;
            cpipe_reg[0] <= clr_reg;
            for (int i = 1; i < N - 1; i++)
            begin
                vpipe_reg[i] <= vpipe_reg[i-1];
                cpipe_reg[i] <= cpipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        jpipe_reg[0] <= jd_reg;
        for (int i = 1; i < N - 1; i++)
            jpipe_reg[i] <= jpipe_reg[i-1];
    end

    // rounding of the finished sums
    logic signed [47:0] rsum [N];
    logic signed [47:0] csum [N];
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            rsum[i] = (acc[i] + 48'sd1024) >>> 11;
            csum[i] = (acc[i] + 48'sd16384) >>> 15;
        end
    end

    // finished line goes to its store one element a cycle from a shift row
    logic signed [ROW_BITS-1:0] rp_row_reg [N];
    logic signed [SAMPLE_BITS-1:0] col_row_reg [N];

    localparam logic [4:0] DONE_STEP = 5'(N + N + 2);
    localparam logic signed [47:0] MAXV = 48'sd2 ** (SAMPLE_BITS - 1) - 48'sd1;
    localparam logic signed [47:0] MINV = -MAXV - 48'sd1;

    logic wb_reg;               // shift row active
    logic wb_row_reg;           // shift row holds a row-pass line
    logic [LW-1:0] wb_idx_reg;
    logic [LW-1:0] wline_reg;   // line the shift row belongs to
    assign rp_we    = wb_reg && wb_row_reg;
    assign rp_waddr = AW'({wline_reg, wb_idx_reg});
    assign rp_wdata = rp_row_reg[0];

    assign busy = (state_reg != S_FILL);

    // column result (a, c) lands at a*8+c, so the block reads out row-major
    assign in_we    = (start && !busy) || (wb_reg && !wb_row_reg);
    assign in_waddr = busy ? AW'({wb_idx_reg, wline_reg}) : fill_reg;
    assign in_wdata = busy ? col_row_reg[0] : sample_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            direction_reg <= 1'b0;
            dir_reg       <= 1'b0;
            fill_reg      <= '0;
            line_reg      <= '0;
            step_reg      <= '0;
            out_reg       <= '0;
            rd_reg        <= 1'b0;
            rd_last_reg   <= 1'b0;
            jd_reg        <= '0;
            feed_reg      <= 1'b0;
            clr_reg       <= 1'b0;
            wb_reg        <= 1'b0;
            wb_row_reg    <= 1'b0;
            wb_idx_reg    <= '0;
            wline_reg     <= '0;
            result_valid  <= 1'b0;
            result_value  <= '0;
            is_last       <= 1'b0;
        end
        else
        begin
            if (direction_we)
                direction_reg <= direction_data;
            // present each streamed element for one cycle
            result_valid <= rd_reg;
            is_last      <= rd_reg && rd_last_reg;
            if (rd_reg)
                result_value <= in_rdata;
            rd_reg      <= (state_reg == S_OUT) && !wb_reg;
            rd_last_reg <= (state_reg == S_OUT) && !wb_reg &&
                           (out_reg == AW'(N * N - 1));
            feed_reg     <= 1'b0;
            clr_reg      <= 1'b0;
            // advance the shift row toward its store
            if (wb_reg)
            begin
                wb_idx_reg <= wb_idx_reg + 1'b1;
                for (int i = 0; i < N - 1; i++)
                begin
                    rp_row_reg[i]  <= rp_row_reg[i+1];
                    col_row_reg[i] <= col_row_reg[i+1];
                end
                if (wb_idx_reg == LW'(N - 1))
                    wb_reg <= 1'b0;
            end
            case (state_reg)
                S_FILL:
                begin
                    if (start)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                        if (fill_reg == AW'(N * N - 1))
                        begin
                            state_reg <= S_ROW;
                            dir_reg   <= direction_reg;
                            line_reg  <= '0;
                            step_reg  <= '0;
                            clr_reg   <= 1'b1;
                        end
                    end
                end
                S_ROW, S_COL:
                begin
                    // steps 0..N-1 issue reads; data lands in the next step
                    if (step_reg < 5'(N))
                    begin
                        feed_reg <= 1'b1;
                        jd_reg   <= j_idx;
                    end
                    if (step_reg == DONE_STEP)
                    begin
                        // last cell has settled; grab the line and restart
                        for (int i = 0; i < N; i++)
                        begin
                            rp_row_reg[i] <= ROW_BITS'(rsum[i]);
                            if (csum[i] > MAXV)
                                col_row_reg[i] <= MINV[SAMPLE_BITS-1:0] - 1'b1;
                            else if (csum[i] < MINV)
                                col_row_reg[i] <= MINV[SAMPLE_BITS-1:0];
                            else
                                col_row_reg[i] <= csum[i][SAMPLE_BITS-1:0];
                        end
                        wb_reg     <= 1'b1;
                        wb_row_reg <= (state_reg == S_ROW);
                        wb_idx_reg <= '0;
                        wline_reg  <= line_reg;
                        step_reg   <= '0;
                        clr_reg    <= 1'b1;
                        line_reg   <= line_reg + 1'b1;
                        if (line_reg == LW'(N - 1))
                            state_reg <= (state_reg == S_ROW) ? S_COL : S_OUT;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_OUT:
                begin
                    // hold until the last column is in the store, then read
                    // the block out in row-major order
                    if (!wb_reg)
                    begin
                        out_reg <= out_reg + 1'b1;
                        if (out_reg == AW'(N * N - 1))
                            state_reg <= S_FILL;
                    end
                end
                default: state_reg <= S_FILL;
            endcase
        end
    end
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb
    import dct8_pkg::*;
();

    localparam int NPIX         = 64;
    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int ITEM_TARGET  = 400;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef enum logic { DIR_FORWARD = 1'b0, DIR_INVERSE = 1'b1 } dct_dir_t;

    typedef struct {
        logic signed [SB-1:0] value;
        logic                 last;
    } pixel_out_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [SB-1:0] sample_value;
    logic                 direction_we;
    logic                 direction_data;
    logic                 result_valid;
    logic signed [SB-1:0] result_value;
    logic                 is_last;

    dct_8x8_forward_inverse u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample_value   (sample_value),
        .direction_we   (direction_we),
        .direction_data (direction_data),
        .result_valid   (result_valid),
        .result_value   (result_value),
        .is_last        (is_last)
    );

    // Model state: one block being filled, plus the mode as last written.
    longint     block_buf [NPIX];
    int         fill_idx;
    dct_dir_t   mode_shadow;
    pixel_out_t pixels_due [$];

    int errors;
    int items_sent;
    int pixels_seen;
    int blocks_fwd;
    int blocks_inv;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cosine weight for basis row k, sample n, in Q13 (0.5*alpha folded in).
    function automatic longint cos_weight(int k, int n);
        int     m;
        longint tab [9];
        tab = '{4096, 4017, 3784, 3406, 2896, 2276, 1567, 799, 0};
        m = ((2 * n + 1) * k) & 31;
        if (k == 0)
            return tab[4];
        if (m > 16)
            m = 32 - m;
        return (m <= 8) ? tab[m] : -tab[16 - m];
    endfunction

    function automatic longint weight(dct_dir_t d, int c, int j);
        return (d == DIR_INVERSE) ? cos_weight(j, c) : cos_weight(c, j);
    endfunction

    // Floor division by 2^s; >>> on longint is arithmetic, i.e. floor.
    function automatic longint floor_div(longint x, int s);
        return x >>> s;
    endfunction

    // Separable 2-D transform of block_buf; pushes 64 expected pixels.
    task automatic transform_block();
        longint rowp [NPIX];
        longint acc;
        longint v;
        begin
            for (int r = 0; r < 8; r++)
                for (int c = 0; c < 8; c++)
                begin
                    acc = 0;
                    for (int j = 0; j < 8; j++)
                        acc += block_buf[r * 8 + j] * weight(mode_shadow, c, j);
                    rowp[r * 8 + c] = floor_div(acc + (64'sd1 <<< 10), 11);
                end
            for (int a = 0; a < 8; a++)
                for (int c = 0; c < 8; c++)
                begin
                    acc = 0;
                    for (int r = 0; r < 8; r++)
                        acc += rowp[r * 8 + c] * weight(mode_shadow, a, r);
                    v = floor_div(acc + (64'sd1 <<< 14), 15);
                    // clamp to the signed sample range
                    if (v > 2047)
                        v = 2047;
                    if (v < -2048)
                        v = -2048;
                    pixels_due.push_back('{SB'(v), (a == 7 && c == 7)});
                end
            if (mode_shadow == DIR_INVERSE)
                blocks_inv++;
            else
                blocks_fwd++;
        end
    endtask

    // Absorb one accepted item; the 64th closes the block.
    task automatic take_sample(logic signed [SB-1:0] s);
        begin
            block_buf[fill_idx] = s;
            fill_idx++;
            items_sent++;
            if (fill_idx == NPIX)
            begin
                fill_idx = 0;
                transform_block();
            end
        end
    endtask

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one item and hold start until it is taken.
    task automatic send_sample(logic signed [SB-1:0] s, bit gaps_on);
        int gap;
        begin
            gap = gaps_on ? pick_gap() : 0;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start        <= 1'b1;
            sample_value <= s;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            take_sample(s);
        end
    endtask

    task automatic drop_start();
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Wait out every outstanding pixel, then let the engine settle.
    task automatic drain();
        begin
            while (pixels_due.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Only write the mode with the block idle and no partial fill pending.
    task automatic set_mode(dct_dir_t d);
        begin
            direction_we   <= 1'b1;
            direction_data <= d;
            @(posedge clk);
            direction_we   <= 1'b0;
            mode_shadow = d;
        end
    endtask

    // Result checker: compare each strobe with the oldest expectation.
    always @(posedge clk)
    begin
        pixel_out_t exp_px;
        if (rst_n && result_valid)
        begin
            pixels_seen++;
            if (pixels_due.size() == 0)
            begin
                $error("unexpected pixel: result_value %0d is_last %0b",
                       result_value, is_last);
                errors++;
            end
            else
            begin
                exp_px = pixels_due.pop_front();
                if (result_value !== exp_px.value)
                begin
                    $error("result_value: expected %0d, got %0d", exp_px.value, result_value);
                    errors++;
                end
                if (is_last !== exp_px.last)
                begin
                    $error("is_last: expected %0b, got %0b", exp_px.last, is_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with neither an accepted item nor a pixel.
    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Directed rows: one fill pattern per block, each row sets the mode too.
    // Known answers: a full-scale flat block forward has a DC far past the
    // sample range, so it clamps to the matching end.
    typedef enum int { PAT_FLAT, PAT_IMPULSE, PAT_CHECKER, PAT_RAMP, PAT_ALT_EXT } pat_t;

    typedef struct {
        dct_dir_t             mode;
        pat_t                 pat;
        logic signed [SB-1:0] val;
        bit                   known;
        logic signed [SB-1:0] dc_want;
    } dir_row_t;

    dir_row_t dir_rows [] = '{
        '{DIR_FORWARD, PAT_FLAT,    12'sd2047,  1'b1, 12'sd2047},
        '{DIR_FORWARD, PAT_FLAT,    -12'sd2048, 1'b1, -12'sd2048},
        '{DIR_FORWARD, PAT_CHECKER, 12'sd2047,  1'b0, 12'sd0},
        '{DIR_INVERSE, PAT_IMPULSE, 12'sd2047,  1'b0, 12'sd0},
        '{DIR_INVERSE, PAT_ALT_EXT, 12'sd0,     1'b0, 12'sd0}
    };

    function automatic logic signed [SB-1:0] pattern_at(pat_t p, logic signed [SB-1:0] v,
                                                        int i);
        case (p)
            PAT_FLAT:    return v;
            PAT_IMPULSE: return (i == 0) ? v : '0;
            PAT_CHECKER: return (((i >> 3) + i) & 1) ? -v : v;
            PAT_RAMP:    return SB'(i * 61 - 1900);
            default:     return (i & 1) ? 12'sh800 : 12'sh7ff;
        endcase
    endfunction

    initial
    begin
        logic signed [SB-1:0] s;
        int kind;
        errors      = 0;
        items_sent  = 0;
        pixels_seen = 0;
        blocks_fwd  = 0;
        blocks_inv  = 0;
        fill_idx    = 0;
        mode_shadow = DIR_FORWARD;
        rst_n          = 1'b0;
        start          = 1'b0;
        sample_value   = '0;
        direction_we   = 1'b0;
        direction_data = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: flat and checker blocks forward, impulse and full-swing blocks inverse.
        foreach (dir_rows[r])
        begin
            set_mode(dir_rows[r].mode);
            for (int i = 0; i < NPIX; i++)
                send_sample(pattern_at(dir_rows[r].pat, dir_rows[r].val, i), 1'b0);
            drop_start();
            if (dir_rows[r].known && pixels_due[0].value !== dir_rows[r].dc_want)
            begin
                $error("result_value: expected %0d, got %0d (model DC)",
                       dir_rows[r].dc_want, pixels_due[0].value);
                errors++;
            end
            drain();
        end

        // Random: whole blocks, mode set at random between blocks, gaps on the sender.
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 1))
                set_mode(dct_dir_t'($urandom_range(0, 1)));
            kind = $urandom_range(0, 3);
            for (int i = 0; i < NPIX; i++)
            begin
                case (kind)
                    0: s = SB'($urandom);
                    1: s = SB'($urandom_range(0, 63)) - 12'sd32;
                    2: s = $urandom_range(0, 1) ? 12'sh7ff : 12'sh800;
                    default: s = (i < 10) ? SB'($urandom) : '0;
                endcase
                send_sample(s, 1'b1);
            end
            drop_start();
            drain();
        end

        $display("covered %0d items in %0d forward and %0d inverse blocks",
                 items_sent, blocks_fwd, blocks_inv);
        $display("checked %0d pixels, %0d mismatches", pixels_seen, errors);
        if (errors == 0 && pixels_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
design/dct8_pkg.sv
design/dct8_cell.sv
design/dct8_ram.sv
design/dct_8x8_forward_inverse.sv
sim/tb.sv
